### rtl/bts_pkg.sv
// Package for the bilinear texture sampler.
// Holds the controller state type, the command struct and shared constants.
// No dependencies.
package bts_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_CAP3,
        S_LERPX,
        S_LERPY
    } state_t;

    typedef struct packed {
        logic       wr;
        logic       load;
        logic       scale;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_en;
        logic [1:0] cap_sel;
        logic       lerp_x;
        logic       lerp_y;
    } ctrl_t;

    localparam logic       ACT_WRITE  = 1'b0;
    localparam logic       ACT_SAMPLE = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    localparam logic [1:0] NB_00 = 2'd0;
    localparam logic [1:0] NB_01 = 2'd1;
    localparam logic [1:0] NB_10 = 2'd2;
    localparam logic [1:0] NB_11 = 2'd3;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

endpackage

### rtl/bilinear_texture_sampler_core.sv
// Top level of the bilinear texture sampler.
// Depends on bts_pkg, bts_ctrl, bts_datapath and bts_ram.
//
// Usage: raise start with an item while busy is low; the transfer happens at
// that clock edge. With action low the item writes one RGBA pixel at
// (pixel_x, pixel_y); the write completes in that cycle, busy stays low and
// no result follows. With action high the item samples at (sample_u,
// sample_v): busy stays high while the coordinates are scaled, the four
// neighbors are read one per cycle from the single read port of the pixel
// store, and the channels are blended in x and then in y. The result
// appears on out_red..out_alpha with out_valid high for exactly one cycle,
// registered after the y blend; busy is low again in that cycle, so the
// next transfer can be taken at the edge that takes the result.
// The receiver cannot stall; every result is taken in its strobe cycle.
// Size registers are written through cfg_we, cfg_index and cfg_data; the
// user must write them only while the block is idle, as the block itself
// does not enforce it. Reset returns the controller to idle and both sizes to
// 128; the pixel store is not cleared and must be written before it is read.
module bilinear_texture_sampler_core #(
    parameter int MAX_WIDTH    = 128,
    parameter int MAX_HEIGHT   = 128,
    parameter int CHANNEL_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic               action,
    input  logic [6:0]         pixel_x,
    input  logic [6:0]         pixel_y,
    input  logic signed [17:0] sample_u,
    input  logic signed [17:0] sample_v,
    input  logic [15:0]        in_red,
    input  logic [15:0]        in_green,
    input  logic [15:0]        in_blue,
    input  logic [15:0]        in_alpha,
    output logic               out_valid,
    output logic [15:0]        out_red,
    output logic [15:0]        out_green,
    output logic [15:0]        out_blue,
    output logic [15:0]        out_alpha
);

    bts_pkg::ctrl_t ctrl;

    bts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .busy   (busy),
        .ctrl   (ctrl)
    );

    bts_datapath #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .sample_u  (sample_u),
        .sample_v  (sample_v),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .in_alpha  (in_alpha),
        .out_valid (out_valid),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha)
    );

endmodule

### rtl/bts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bts_ctrl.sv
// Controller state machine of the bilinear texture sampler.
// Depends on bts_pkg for the state type and the command struct.
module bts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           action,
    output logic           busy,
    output bts_pkg::ctrl_t ctrl
);

    bts_pkg::state_t state_reg;
    bts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ctrl         = '0;
        busy         = 1'b1;
        case (state_reg)
            bts_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (action == bts_pkg::ACT_SAMPLE)
                    begin
                        ctrl.load  = 1'b1;
                        state_next = bts_pkg::S_SCALE;
                    end
                    else
                    begin
                        ctrl.wr = 1'b1;
                    end
                end
            end
            bts_pkg::S_SCALE:
            begin
                ctrl.scale = 1'b1;
                state_next = bts_pkg::S_RD0;
            end
            bts_pkg::S_RD0:
            begin
                ctrl.rd_en  = 1'b1;
                ctrl.rd_sel = bts_pkg::NB_00;
                state_next  = bts_pkg::S_RD1;
            end
            bts_pkg::S_RD1:
            begin
                ctrl.rd_en   = 1'b1;
                ctrl.rd_sel  = bts_pkg::NB_01;
                ctrl.cap_en  = 1'b1;
                ctrl.cap_sel = bts_pkg::NB_00;
                state_next   = bts_pkg::S_RD2;
            end
            bts_pkg::S_RD2:
            begin
                ctrl.rd_en   = 1'b1;
                ctrl.rd_sel  = bts_pkg::NB_10;
                ctrl.cap_en  = 1'b1;
                ctrl.cap_sel = bts_pkg::NB_01;
                state_next   = bts_pkg::S_RD3;
            end
            bts_pkg::S_RD3:
            begin
                ctrl.rd_en   = 1'b1;
                ctrl.rd_sel  = bts_pkg::NB_11;
                ctrl.cap_en  = 1'b1;
                ctrl.cap_sel = bts_pkg::NB_10;
                state_next   = bts_pkg::S_CAP3;
            end
            bts_pkg::S_CAP3:
            begin
                ctrl.cap_en  = 1'b1;
                ctrl.cap_sel = bts_pkg::NB_11;
                state_next   = bts_pkg::S_LERPX;
            end
            bts_pkg::S_LERPX:
            begin
                ctrl.lerp_x = 1'b1;
                state_next  = bts_pkg::S_LERPY;
            end
            bts_pkg::S_LERPY:
            begin
                ctrl.lerp_y = 1'b1;
                state_next  = bts_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bts_pkg::S_IDLE;
            end
        endcase
    end

    a_lerpy_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.lerp_y |=> (state_reg == bts_pkg::S_IDLE))
        else $error("sample did not return to idle after the y blend");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr |-> (!busy && start))
        else $error("store write issued outside an accepted transfer");

    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && action == bts_pkg::ACT_SAMPLE))
        else $error("controller left idle without a sample transfer");

    a_read_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.rd_en && ctrl.rd_sel == bts_pkg::NB_11) |=>
        (ctrl.cap_en && ctrl.cap_sel == bts_pkg::NB_11))
        else $error("last neighbor read not captured");

endmodule

### rtl/bts_datapath.sv
// Datapath of the bilinear texture sampler: size registers, coordinate
// scaling, neighbor addressing, pixel store and channel blending.
// Depends on bts_pkg and bts_ram.
module bts_datapath #(
    parameter int MAX_WIDTH    = 128,
    parameter int MAX_HEIGHT   = 128,
    parameter int CHANNEL_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bts_pkg::ctrl_t     ctrl,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic [6:0]         pixel_x,
    input  logic [6:0]         pixel_y,
    input  logic signed [17:0] sample_u,
    input  logic signed [17:0] sample_v,
    input  logic [15:0]        in_red,
    input  logic [15:0]        in_green,
    input  logic [15:0]        in_blue,
    input  logic [15:0]        in_alpha,
    output logic               out_valid,
    output logic [15:0]        out_red,
    output logic [15:0]        out_green,
    output logic [15:0]        out_blue,
    output logic [15:0]        out_alpha
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [15:0] CHAN_MASK = 16'((17'(1) << CHANNEL_BITS) - 17'(1));

    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    logic [7:0]  w_eff;
    logic [7:0]  h_eff;
    logic [7:0]  wm1;
    logic [7:0]  hm1;

    logic [17:0] u_reg;
    logic [17:0] v_reg;
    logic [16:0] u_cl;
    logic [16:0] v_cl;
    logic [24:0] ix;
    logic [24:0] iy;
    logic [15:0] fx_reg;
    logic [15:0] fy_reg;
    logic [7:0]  i0_reg;
    logic [7:0]  i1_reg;
    logic [7:0]  j0_reg;
    logic [7:0]  j1_reg;

    logic            wr_ok;
    logic [AW-1:0]   waddr;
    logic [63:0]     wdata;
    logic [7:0]      rd_i;
    logic [7:0]      rd_j;
    logic [AW-1:0]   raddr;
    logic [63:0]     rdata;

    logic [63:0] pix_reg [4];
    logic [31:0] top_reg [4];
    logic [31:0] bot_reg [4];
    logic [15:0] res_reg [4];
    logic        out_valid_reg;

    function automatic logic [7:0] eff_size(input logic [7:0] r, input logic [12:0] mx);
        logic [7:0] s;
        s = r;
        if (r == 8'd0)
        begin
            s = 8'd1;
        end
        else if ({5'd0, r} > mx)
        begin
            s = mx[7:0];
        end
        return s;
    endfunction

    function automatic logic [16:0] clamp_coord(input logic [17:0] raw);
        logic [16:0] c;
        c = raw[16:0];
        if (raw[17])
        begin
            c = 17'd0;
        end
        else if (raw[16:0] > bts_pkg::ONE_Q16)
        begin
            c = bts_pkg::ONE_Q16;
        end
        return c;
    endfunction

    // a + f * (b - a), with a in the upper half of a 32-bit fixed-point value.
    function automatic logic [31:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] f);
        logic signed [16:0] d;
        logic signed [33:0] p;
        logic signed [33:0] s;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, f});
        s = $signed({2'b00, a, 16'h0000}) + p;
        return s[31:0];
    endfunction

    function automatic logic [15:0] lerp32(input logic [31:0] a, input logic [31:0] b,
                                           input logic [15:0] f);
        logic signed [32:0] d;
        logic signed [49:0] p;
        logic signed [49:0] s;
        logic [48:0]        r;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, f});
        s = $signed({2'b00, a, 16'h0000}) + p;
        r = {1'b0, s[47:0]} + 49'h0_8000_0000;
        return r[47:32];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd128;
            height_reg <= 8'd128;
        end
        else if (cfg_we)
        begin
            if (cfg_index == bts_pkg::REG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else if (cfg_index == bts_pkg::REG_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    assign w_eff = eff_size(width_reg, 13'(MAX_WIDTH));
    assign h_eff = eff_size(height_reg, 13'(MAX_HEIGHT));
    assign wm1   = w_eff - 8'd1;
    assign hm1   = h_eff - 8'd1;

    // Writes outside the size in use are dropped.
    assign wr_ok = ctrl.wr && ({1'b0, pixel_x} < w_eff) && ({1'b0, pixel_y} < h_eff);
    assign waddr = AW'(pixel_y) * AW'(MAX_WIDTH) + AW'(pixel_x);
    assign wdata = {in_alpha & CHAN_MASK, in_blue & CHAN_MASK,
                    in_green & CHAN_MASK, in_red & CHAN_MASK};

    assign u_cl = clamp_coord(u_reg);
    assign v_cl = clamp_coord(v_reg);
    assign ix   = 25'(u_cl) * 25'(wm1);
    assign iy   = 25'(v_cl) * 25'(hm1);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            u_reg <= sample_u;
            v_reg <= sample_v;
        end
        if (ctrl.scale)
        begin
            fx_reg <= ix[15:0];
            fy_reg <= iy[15:0];
            i0_reg <= ix[23:16];
            j0_reg <= iy[23:16];
            i1_reg <= (ix[23:16] < wm1) ? ix[23:16] + 8'd1 : wm1;
            j1_reg <= (iy[23:16] < hm1) ? iy[23:16] + 8'd1 : hm1;
        end
    end

    assign rd_i  = ctrl.rd_sel[0] ? i1_reg : i0_reg;
    assign rd_j  = ctrl.rd_sel[1] ? j1_reg : j0_reg;
    assign raddr = AW'(rd_j) * AW'(MAX_WIDTH) + AW'(rd_i);

    bts_ram #(
        .WIDTH(64),
        .DEPTH(DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_ok),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ctrl.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.cap_en)
        begin
            pix_reg[ctrl.cap_sel] <= rdata;
        end
        for (int ch = 0; ch < 4; ch++)
        begin
            if (ctrl.lerp_x)
            begin
                top_reg[ch] <= lerp16(pix_reg[bts_pkg::NB_00][16*ch +: 16],
                                      pix_reg[bts_pkg::NB_01][16*ch +: 16], fx_reg);
                bot_reg[ch] <= lerp16(pix_reg[bts_pkg::NB_10][16*ch +: 16],
                                      pix_reg[bts_pkg::NB_11][16*ch +: 16], fx_reg);
            end
            if (ctrl.lerp_y)
            begin
                res_reg[ch] <= lerp32(top_reg[ch], bot_reg[ch], fy_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= ctrl.lerp_y;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = res_reg[0];
    assign out_green = res_reg[1];
    assign out_blue  = res_reg[2];
    assign out_alpha = res_reg[3];

endmodule

### dv/bts_sample_checker.sv
// Checker for the bilinear texture sampler: keeps its own image and size copies,
// predicts every sample result and compares it with the strobed output.
// Depends on bts_pkg.
module bts_sample_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               start,
    input  logic               busy,
    input  logic               action,
    input  logic [6:0]         pixel_x,
    input  logic [6:0]         pixel_y,
    input  logic signed [17:0] sample_u,
    input  logic signed [17:0] sample_v,
    input  logic [15:0]        in_red,
    input  logic [15:0]        in_green,
    input  logic [15:0]        in_blue,
    input  logic [15:0]        in_alpha,
    input  logic               out_valid,
    input  logic [15:0]        out_red,
    input  logic [15:0]        out_green,
    input  logic [15:0]        out_blue,
    input  logic [15:0]        out_alpha,
    output int                 errors,
    output int                 pending
);

    localparam int IMG_DIM = 128;

    logic [63:0] image_mem [IMG_DIM][IMG_DIM];
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    logic [63:0] colors_due [$];

    function automatic int unsigned eff_size(logic [7:0] r);
        if (r == 8'd0)
            return 1;
        if (r > IMG_DIM)
            return IMG_DIM;
        return r;
    endfunction

    function automatic logic [16:0] clamp_q16(logic [17:0] raw);
        if (raw[17])
            return 17'd0;
        if (raw[16:0] > bts_pkg::ONE_Q16)
            return bts_pkg::ONE_Q16;
        return raw[16:0];
    endfunction

    function automatic logic [63:0] bilerp(logic [17:0] u_raw, logic [17:0] v_raw);
        int unsigned w, h, i0, i1, j0, j1;
        longint unsigned ix, iy, fx, fy, top, bot, acc;
        logic [63:0] p00, p01, p10, p11, res;
        w  = eff_size(width_reg);
        h  = eff_size(height_reg);
        ix = longint'(clamp_q16(u_raw)) * (w - 1);
        iy = longint'(clamp_q16(v_raw)) * (h - 1);
        fx = ix & 64'hFFFF;
        fy = iy & 64'hFFFF;
        i0 = 32'(ix >> 16);
        j0 = 32'(iy >> 16);
        i1 = i0 + 1;
        j1 = j0 + 1;
        if (i0 > w - 1) i0 = w - 1;
        if (i1 > w - 1) i1 = w - 1;
        if (j0 > h - 1) j0 = h - 1;
        if (j1 > h - 1) j1 = h - 1;
        p00 = image_mem[j0][i0];
        p01 = image_mem[j0][i1];
        p10 = image_mem[j1][i0];
        p11 = image_mem[j1][i1];
        for (int ch = 0; ch < 4; ch++)
        begin
            top = (65536 - fx) * p00[16*ch +: 16] + fx * p01[16*ch +: 16];
            bot = (65536 - fx) * p10[16*ch +: 16] + fx * p11[16*ch +: 16];
            acc = (65536 - fy) * top + fy * bot;
            res[16*ch +: 16] = 16'((acc + 64'h8000_0000) >> 32);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd128;
            height_reg <= 8'd128;
            colors_due.delete();
            errors     <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == bts_pkg::REG_WIDTH)
                    width_reg <= cfg_data;
                else if (cfg_index == bts_pkg::REG_HEIGHT)
                    height_reg <= cfg_data;
            end
            if (start && !busy)
            begin
                if (action == bts_pkg::ACT_SAMPLE)
                    colors_due = {colors_due, bilerp(sample_u, sample_v)};
                else if (pixel_x < eff_size(width_reg) && pixel_y < eff_size(height_reg))
                    image_mem[pixel_y][pixel_x] <= {in_alpha, in_blue, in_green, in_red};
            end
            if (out_valid)
            begin
                if (colors_due.size() == 0)
                begin
                    $display("%0t: result with nothing expected: got %h", $time,
                             {out_alpha, out_blue, out_green, out_red});
                    errors <= errors + 1;
                end
                else
                begin
                    logic [63:0] want;
                    logic [63:0] got;
                    int          bad;
                    want = colors_due.pop_front();
                    got  = {out_alpha, out_blue, out_green, out_red};
                    bad  = 0;
                    for (int ch = 0; ch < 4; ch++)
                    begin
                        if (want[16*ch +: 16] !== got[16*ch +: 16])
                        begin
                            $display("%0t: channel %0d mismatch: expected %h actual %h",
                                     $time, ch, want[16*ch +: 16], got[16*ch +: 16]);
                            bad++;
                        end
                    end
                    errors <= errors + bad;
                end
            end
        end
    end

    assign pending = colors_due.size();

endmodule

### dv/tb_bilinear_texture_sampler_core.sv
// Testbench top for bilinear_texture_sampler_core: drives size writes, pixel
// writes and samples with random gaps; bts_sample_checker does the checking.
// Depends on bts_pkg, the core RTL and dv/bts_sample_checker.sv.
module tb_bilinear_texture_sampler_core;

    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;
    localparam int         IMG_DIM     = 128;
    localparam int         SETTLE      = 16;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [7:0]         cfg_data;
    logic               start;
    logic               busy;
    logic               action;
    logic [6:0]         pixel_x;
    logic [6:0]         pixel_y;
    logic signed [17:0] sample_u;
    logic signed [17:0] sample_v;
    logic [15:0]        in_red;
    logic [15:0]        in_green;
    logic [15:0]        in_blue;
    logic [15:0]        in_alpha;
    logic               out_valid;
    logic [15:0]        out_red;
    logic [15:0]        out_green;
    logic [15:0]        out_blue;
    logic [15:0]        out_alpha;
    int                 errors;
    int                 pending;

    // Pixels already written, so that a sample never touches an unwritten entry.
    bit          written [IMG_DIM][IMG_DIM];
    logic [7:0]  width_sh;
    logic [7:0]  height_sh;
    bit          no_gaps;

    bilinear_texture_sampler_core u_top (.*);

    bts_sample_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int unsigned eff_size(logic [7:0] r);
        if (r == 8'd0)
            return 1;
        if (r > IMG_DIM)
            return IMG_DIM;
        return r;
    endfunction

    function automatic int unsigned cell_of(logic [17:0] raw, int unsigned n);
        longint unsigned pos;
        logic [16:0]     c;
        c   = raw[17] ? 17'd0 :
              (raw[16:0] > bts_pkg::ONE_Q16 ? bts_pkg::ONE_Q16 : raw[16:0]);
        pos = longint'(c) * (n - 1);
        return 32'(pos >> 16);
    endfunction

    task automatic send(logic act, logic [6:0] x, logic [6:0] y, logic [17:0] u,
                        logic [17:0] v, logic [63:0] rgba);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action   <= act;
        pixel_x  <= x;
        pixel_y  <= y;
        sample_u <= u;
        sample_v <= v;
        {in_alpha, in_blue, in_green, in_red} <= rgba;
        start    <= 1'b1;
        // busy only moves at rising edges, so its value at the falling edge holds.
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        if (act == bts_pkg::ACT_WRITE && x < eff_size(width_sh) && y < eff_size(height_sh))
            written[y][x] = 1'b1;
    endtask

    task automatic put_pixel(int unsigned x, int unsigned y);
        logic [63:0] rgba;
        rgba = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: rgba = '0;
            1: rgba = '1;
            default: ;
        endcase
        send(bts_pkg::ACT_WRITE, 7'(x), 7'(y), 18'($urandom), 18'($urandom), rgba);
    endtask

    // Writes any neighbor that is still empty, then samples.
    task automatic sample_at(logic [17:0] u, logic [17:0] v);
        int unsigned w, h, i0, i1, j0, j1;
        w  = eff_size(width_sh);
        h  = eff_size(height_sh);
        i0 = cell_of(u, w);
        j0 = cell_of(v, h);
        i1 = (i0 + 1 > w - 1) ? w - 1 : i0 + 1;
        j1 = (j0 + 1 > h - 1) ? h - 1 : j0 + 1;
        if (!written[j0][i0]) put_pixel(i0, j0);
        if (!written[j0][i1]) put_pixel(i1, j0);
        if (!written[j1][i0]) put_pixel(i0, j1);
        if (!written[j1][i1]) put_pixel(i1, j1);
        send(bts_pkg::ACT_SAMPLE, 7'($urandom), 7'($urandom), u, v, {$urandom, $urandom});
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // cfg_we returns low after each write before the next can begin, so that
    // back-to-back writes never drive the enable twice in one step.
    task automatic set_reg(logic [1:0] idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == bts_pkg::REG_WIDTH)
            width_sh = val;
        else if (idx == bts_pkg::REG_HEIGHT)
            height_sh = val;
        @(posedge clk);
    endtask

    function automatic logic [17:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 18'd0;
            1: return 18'(bts_pkg::ONE_Q16);
            2, 3: return 18'($urandom);
            default: return 18'($urandom_range(0, 65536));
        endcase
    endfunction

    initial
    begin
        logic [7:0] sizes [8][2];
        sizes = '{'{8'd128, 8'd128}, '{8'd1, 8'd1}, '{8'd0, 8'd0}, '{8'd255, 8'd200},
                  '{8'd2, 8'd3}, '{8'd128, 8'd1}, '{8'd1, 8'd128}, '{8'd7, 8'd5}};
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= bts_pkg::REG_WIDTH;
        cfg_data  <= '0;
        start     <= 1'b0;
        action    <= bts_pkg::ACT_WRITE;
        pixel_x   <= '0;
        pixel_y   <= '0;
        sample_u  <= '0;
        sample_v  <= '0;
        {in_alpha, in_blue, in_green, in_red} <= '0;
        width_sh  = 8'd128;
        height_sh = 8'd128;
        no_gaps   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corners with extreme colors, then extreme coordinates.
        put_pixel(0, 0);
        send(bts_pkg::ACT_WRITE, 7'd127, 7'd127, '0, '0, '1);
        send(bts_pkg::ACT_WRITE, 7'd127, 7'd0, '0, '0, '0);
        send(bts_pkg::ACT_WRITE, 7'd0, 7'd127, '0, '0, 64'hFFFF_0000_FFFF_0000);
        sample_at(18'd0, 18'd0);
        sample_at(18'(bts_pkg::ONE_Q16), 18'(bts_pkg::ONE_Q16));
        sample_at(18'h20000, 18'h1FFFF);
        sample_at(18'h1FFFF, 18'h3FFFF);
        sample_at(18'd65535, 18'd1);
        sample_at(18'd65537, 18'd32768);
        sample_at(18'd32768, 18'd32768);
        drain();
        set_reg(REG_SPARE_A, 8'd3);
        set_reg(REG_SPARE_B, 8'd9);
        set_reg(bts_pkg::REG_WIDTH, 8'd4);
        set_reg(bts_pkg::REG_HEIGHT, 8'd4);
        send(bts_pkg::ACT_WRITE, 7'd4, 7'd0, '0, '0, '1);
        send(bts_pkg::ACT_WRITE, 7'd0, 7'd4, '0, '0, '1);
        send(bts_pkg::ACT_WRITE, 7'd127, 7'd127, '0, '0, 64'h1234_5678_9ABC_DEF0);
        sample_at(18'(bts_pkg::ONE_Q16), 18'(bts_pkg::ONE_Q16));
        sample_at(18'd21845, 18'd43690);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            set_reg(bts_pkg::REG_WIDTH, sizes[ph][0]);
            set_reg(bts_pkg::REG_HEIGHT, sizes[ph][1]);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 38; n++)
            begin
                if ($urandom_range(0, 9) < 7)
                    sample_at(rand_coord(), rand_coord());
                else if ($urandom_range(0, 1) == 0)
                    put_pixel($urandom_range(0, 127), $urandom_range(0, 127));
                else
                    put_pixel($urandom_range(0, eff_size(width_sh) - 1),
                              $urandom_range(0, eff_size(height_sh) - 1));
                if ($urandom_range(0, 15) == 0)
                    no_gaps = !no_gaps;
            end
        end

        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/bts_pkg.sv
rtl/bts_ram.sv
rtl/bts_ctrl.sv
rtl/bts_datapath.sv
rtl/bilinear_texture_sampler_core.sv
dv/bts_sample_checker.sv
dv/tb_bilinear_texture_sampler_core.sv
